>>> hdl/assert_macros.svh
// Assertion macros used by the RTL back end (ssso_back.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, prop)

`endif

`endif

>>> hdl/ssso_pkg.sv
package ssso_pkg;

  localparam int unsigned BitsPerDigit = 16;
  localparam int unsigned CntW         = 4;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QPtrW        = 2;
  localparam int unsigned QCntW        = 3;
  localparam int unsigned RecipTen     = 52429;
  localparam int unsigned RecipShift   = 19;
  localparam logic [7:0]  EnableBase   = 8'h10;

  typedef struct packed {
    logic [15:0] word;
    logic [1:0]  pos;
    logic        last;
  } digit_word_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] act;
    case (digit)
      4'd0:    act = 8'hFC;
      4'd1:    act = 8'h60;
      4'd2:    act = 8'hDA;
      4'd3:    act = 8'hF2;
      4'd4:    act = 8'h66;
      4'd5:    act = 8'hB6;
      4'd6:    act = 8'hBE;
      4'd7:    act = 8'hE0;
      4'd8:    act = 8'hFE;
      4'd9:    act = 8'hF6;
      default: act = 8'h00;
    endcase
    return ~act;
  endfunction

endpackage

>>> hdl/ssso_front.sv
module ssso_front #(
  parameter int unsigned DIGITS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          in_value_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output ssso_pkg::digit_word_t push_data_o
);

  localparam logic [1:0] LastPos = 2'(DIGITS - 1);

  logic        busy_q, busy_d;
  logic [15:0] v_q, v_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot_x10;
  logic [3:0]  rem;
  logic        push;
  logic        accept;

  assign prod     = 32'(v_q) * 32'(ssso_pkg::RecipTen);
  assign quot     = prod[31:ssso_pkg::RecipShift];
  assign quot_x10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
  assign rem      = 4'(v_q - quot_x10);

  assign push         = busy_q && push_ready_i;
  assign push_valid_o = busy_q;
  assign in_ready_o   = !busy_q || (push && (pos_q == LastPos));
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    push_data_o.word = {ssso_pkg::EnableBase << pos_q, ssso_pkg::seg_pattern(rem)};
    push_data_o.pos  = pos_q;
    push_data_o.last = (pos_q == LastPos);
  end

  always_comb begin
    busy_d = busy_q;
    v_d    = v_q;
    pos_d  = pos_q;
    if (push) begin
      v_d   = 16'(quot);
      pos_d = pos_q + 2'd1;
      if (pos_q == LastPos) begin
        busy_d = 1'b0;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      v_d    = in_value_i;
      pos_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

endmodule

>>> hdl/ssso_queue.sv
module ssso_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  ssso_pkg::digit_word_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output ssso_pkg::digit_word_t pop_data_o
);

  localparam logic [ssso_pkg::QCntW-1:0] Full = ssso_pkg::QCntW'(ssso_pkg::QueueDepth);

  ssso_pkg::digit_word_t mem_q [ssso_pkg::QueueDepth];
  logic [ssso_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ssso_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/ssso_back.sv
`include "assert_macros.svh"

module ssso_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  ssso_pkg::digit_word_t pop_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_data_o,
  output logic                  out_last_o
);

  localparam logic [ssso_pkg::CntW-1:0] LastBit = ssso_pkg::CntW'(ssso_pkg::BitsPerDigit - 1);

  logic                     sh_valid_q, sh_valid_d;
  logic [15:0]              sh_word_q, sh_word_d;
  logic [ssso_pkg::CntW-1:0] sh_cnt_q, sh_cnt_d;
  logic [1:0]               sh_pos_q, sh_pos_d;
  logic                     sh_last_q, sh_last_d;
  logic                     o_valid_q, o_valid_d;
  logic [7:0]               o_data_q, o_data_d;
  logic                     o_last_q, o_last_d;
  logic                     out_free, emit, final_bit, pop;

  assign out_free    = !o_valid_q || out_ready_i;
  assign emit        = out_free && sh_valid_q;
  assign final_bit   = (sh_cnt_q == LastBit);
  assign pop         = pop_valid_i && (!sh_valid_q || (emit && final_bit));
  assign pop_ready_o = !sh_valid_q || (emit && final_bit);

  always_comb begin
    sh_valid_d = sh_valid_q;
    sh_word_d  = sh_word_q;
    sh_cnt_d   = sh_cnt_q;
    sh_pos_d   = sh_pos_q;
    sh_last_d  = sh_last_q;
    o_valid_d  = o_valid_q;
    o_data_d   = o_data_q;
    o_last_d   = o_last_q;
    if (out_free) begin
      o_valid_d = 1'b0;
    end
    if (emit) begin
      o_valid_d = 1'b1;
      o_data_d  = {4'b0000, sh_pos_q, final_bit, sh_word_q[0]};
      o_last_d  = final_bit && sh_last_q;
      sh_word_d = {1'b0, sh_word_q[15:1]};
      sh_cnt_d  = sh_cnt_q + 1'b1;
      if (final_bit) begin
        sh_valid_d = 1'b0;
      end
    end
    if (pop) begin
      sh_valid_d = 1'b1;
      sh_word_d  = pop_data_i.word;
      sh_cnt_d   = '0;
      sh_pos_d   = pop_data_i.pos;
      sh_last_d  = pop_data_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_valid_q <= 1'b0;
      sh_cnt_q   <= '0;
      o_valid_q  <= 1'b0;
    end else begin
      sh_valid_q <= sh_valid_d;
      sh_cnt_q   <= sh_cnt_d;
      o_valid_q  <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_word_q <= sh_word_d;
    sh_pos_q  <= sh_pos_d;
    sh_last_q <= sh_last_d;
    o_data_q  <= o_data_d;
    o_last_q  <= o_last_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;
  assign out_last_o  = o_last_q;

  `ASSERT_PROP(a_last_on_latch, clk_i, rst_ni, (o_valid_q && o_last_q) |-> o_data_q[1])
  `ASSERT_PROP(a_enable_onehot, clk_i, rst_ni, (sh_valid_q && sh_cnt_q == '0) |-> $onehot(sh_word_q[15:8]))
  `ASSERT_PROP(a_digit_continues, clk_i, rst_ni, (emit && !final_bit) |=> sh_valid_q)
  `ASSERT_NEVER(a_no_pop_mid_digit, clk_i, rst_ni, pop && sh_valid_q && !final_bit)

endmodule

>>> hdl/seven_segment_shift_out_top.sv
// Channel   Dir  tdata (low bit up)                                 tlast
// s_axis    in   value[15:0]                                        -
// m_axis    out  serial_bit, latch_after, digit_position[1:0], pad  last
//
// Each number produces DIGITS*16 output transfers, one bit per cycle when the
// output is not stalled. The bit shifter in the back end limits the throughput;
// the front end does one division by ten per cycle while the digit queue has room.
// A four-entry digit queue lets the front end take the next number while bits
// of the previous one are still being shifted out.
// Reset is asynchronous and active low; no clearing pass is needed.
module seven_segment_shift_out_top #(
  parameter int unsigned DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // value[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // serial_bit, latch_after, digit_position[1:0], 4'b0
  output logic        m_axis_tlast
);

  ssso_pkg::digit_word_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop_ready;

  ssso_front #(
    .DIGITS(DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  ssso_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  ssso_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned BitsPerDigit = 16;
  localparam logic [7:0] EnableBase = 8'h10;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam logic [7:0] SegLit [10] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
  };

  typedef struct packed {
    logic       serial_bit;
    logic       latch_after;
    logic [1:0] digit_pos;
    logic       last;
  } shift_bit_t;

  class shift_bit_tracker;
    shift_bit_t pending_bits[$];
    int unsigned fault_count;

    function new();
      fault_count = 0;
    endfunction

    function void note_value(input logic [15:0] value);
      int unsigned rest;
      logic [3:0]  digit;
      logic [15:0] word;
      shift_bit_t  item;
      rest = value;
      for (int unsigned pos = 0; pos < DigitCount; pos++) begin
        digit = 4'(rest % 10);
        rest = rest / 10;
        word = {8'(EnableBase << pos), ~SegLit[digit]};
        for (int unsigned b = 0; b < BitsPerDigit; b++) begin
          item.serial_bit = word[b];
          item.latch_after = (b == BitsPerDigit - 1);
          item.digit_pos = 2'(pos);
          item.last = (b == BitsPerDigit - 1) && (pos == DigitCount - 1);
          pending_bits.push_back(item);
        end
      end
    endfunction

    function void check_bit(input logic [7:0] data, input logic tlast);
      shift_bit_t want;
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected transfer, data %h last %b", $time, data, tlast);
        fault_count++;
        return;
      end
      want = pending_bits.pop_front();
      if (data[0] !== want.serial_bit) begin
        $display("%0t: serial_bit expected %b actual %b", $time, want.serial_bit, data[0]);
        fault_count++;
      end
      if (data[1] !== want.latch_after) begin
        $display("%0t: latch_after expected %b actual %b", $time, want.latch_after, data[1]);
        fault_count++;
      end
      if (data[3:2] !== want.digit_pos) begin
        $display("%0t: digit_position expected %0d actual %0d", $time, want.digit_pos,
                 data[3:2]);
        fault_count++;
      end
      if (data[7:4] !== 4'b0) begin
        $display("%0t: padding expected 0 actual %h", $time, data[7:4]);
        fault_count++;
      end
      if (tlast !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, tlast);
        fault_count++;
      end
    endfunction

    function int unsigned pending();
      return pending_bits.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  shift_bit_tracker tracker = new();

  seven_segment_shift_out_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("seven_segment_shift_out_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_bit(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_value(input logic [15:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_value(value);
  endtask

  task automatic send_random_values(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        send_value(16'($urandom_range(0, 9999)));
      end else begin
        send_value(16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    logic [15:0] directed_values[$];
    directed_values = '{16'd0, 16'd1111, 16'd2222, 16'd3333, 16'd4444, 16'd5555,
                        16'd6666, 16'd7777, 16'd8888, 16'd9999, 16'd65535, 16'd10000,
                        16'd12345, 16'd60009, 16'd1, 16'd10, 16'd100, 16'd1000,
                        16'd9, 16'd90, 16'd900, 16'd9000, 16'd4321};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_values[i]) send_value(directed_values[i]);

    idle_pct = 0;
    stall_pct = 0;
    send_random_values(20);
    idle_pct = 51;
    stall_pct = 0;
    send_random_values(20);
    idle_pct = 0;
    stall_pct = 51;
    send_random_values(20);
    idle_pct = 24;
    stall_pct = 24;
    send_random_values(20);
    s_axis_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.fault_count == 0) begin
      $display("seven_segment_shift_out_top: match");
    end else begin
      $display("seven_segment_shift_out_top: mismatch");
    end
    $finish;
  end

endmodule
